[sv/scbgs_pkg.sv]
package scbgs_pkg;

    // Store geometry.
    localparam int MAX_WIDTH   = 320;
    localparam int MAX_HEIGHT  = 240;
    localparam int NUM_SAMPLES = 20;

    localparam int PIXELS    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W    = $clog2(PIXELS);
    localparam int SLOT_W    = $clog2(NUM_SAMPLES);
    localparam int CNT_W     = $clog2(NUM_SAMPLES + 1);
    localparam int CMP_W     = (CNT_W > 5) ? CNT_W : 5;
    localparam int COLOUR_W  = 24;
    localparam int COORD_W   = 16;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_MATCH_RADIUS     = 3'd0;
    localparam logic [2:0] REG_REQUIRED_MATCHES = 3'd1;
    localparam logic [2:0] REG_SAMPLES_IN_USE   = 3'd2;
    localparam logic [2:0] REG_FRAME_WIDTH      = 3'd3;
    localparam logic [2:0] REG_FRAME_HEIGHT     = 3'd4;

    // Item modes.
    localparam logic MODE_CLASSIFY = 1'b0;
    localparam logic MODE_LOAD     = 1'b1;

    typedef struct packed {
        logic [4:0]          near_slot;
        logic signed [1:0]   step_y;
        logic signed [1:0]   step_x;
        logic [4:0]          near_draw;
        logic [4:0]          own_draw;
        logic [4:0]          own_slot;
        logic [7:0]          chan2;
        logic [7:0]          chan1;
        logic [7:0]          chan0;
        logic [7:0]          pos_y;
        logic [8:0]          pos_x;
    } item_t;

    typedef logic [NUM_SAMPLES-1:0][COLOUR_W-1:0] sample_word_t;

endpackage

[sv/sample_consensus_background_subtract_unit.sv]
// Sample-consensus background subtraction for a stream of colour pixels.
// Each pixel position owns one wide word of the sample memory that holds all
// of its stored colour samples. An input word on the s_ side either loads one
// sample (tuser high) or classifies a pixel (tuser low); a classify word
// produces exactly one output word on the m_ side, bit 0 being the foreground
// flag, while a load produces none.
// A classify word passes through memory read, distance compare and decision,
// then frees the input, first passing a neighbour write state when a neighbour
// sample is rewritten: own and neighbour updates share the single write port
// one after the other, so the neighbour write wins on a shared entry. A classify
// outside the store goes straight to the decision; a load writes its sample in
// a load state, or is dropped outside the store. Words are handled one at a
// time; the next input word is taken as soon as the previous one has left its
// working states, even while its result still sits in the output register. If
// the receiver stalls and the output register is still full when a new decision
// is due, the block waits in the decision state and holds s_tready low until the
// register frees. Reset returns the configuration registers to their defaults
// and empties the output register. The sample memory is not cleared, so the
// user must have every sample loaded before its pixel is classified and must
// have configuration written only when idle; the block enforces neither.
module sample_consensus_background_subtract_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata fields from bit 0: pos_x, pos_y, chan0, chan1, chan2, own_slot,
    // own_draw, near_draw, step_x, step_y, near_slot, zero fill.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    // s_tuser fields from bit 0: mode.
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields from bit 0: foreground, zero fill.
    output logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_NEAR   = 3'd5;

    // Configuration registers. The squared radius is kept alongside the
    // radius so that the compare path carries no multiplier of its own.
    logic [8:0]  match_radius_reg;
    logic [17:0] radius_sq_reg;
    logic [4:0]  required_matches_reg;
    logic [4:0]  samples_in_use_reg;
    logic [8:0]  frame_width_reg;
    logic [7:0]  frame_height_reg;

    logic [2:0]  cfg_index;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_radius_reg     <= 9'd20;
            radius_sq_reg        <= 18'd400;
            required_matches_reg <= 5'd2;
            samples_in_use_reg   <= 5'd20;
            frame_width_reg      <= 9'd320;
            frame_height_reg     <= 8'd240;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                scbgs_pkg::REG_MATCH_RADIUS:
                begin
                    match_radius_reg <= pwdata[8:0];
                    radius_sq_reg    <= {9'd0, pwdata[8:0]} * {9'd0, pwdata[8:0]};
                end
                scbgs_pkg::REG_REQUIRED_MATCHES: required_matches_reg <= pwdata[4:0];
                scbgs_pkg::REG_SAMPLES_IN_USE:   samples_in_use_reg   <= pwdata[4:0];
                scbgs_pkg::REG_FRAME_WIDTH:      frame_width_reg      <= pwdata[8:0];
                scbgs_pkg::REG_FRAME_HEIGHT:     frame_height_reg     <= pwdata[7:0];
                default:                         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            scbgs_pkg::REG_MATCH_RADIUS:     prdata = 32'(match_radius_reg);
            scbgs_pkg::REG_REQUIRED_MATCHES: prdata = 32'(required_matches_reg);
            scbgs_pkg::REG_SAMPLES_IN_USE:   prdata = 32'(samples_in_use_reg);
            scbgs_pkg::REG_FRAME_WIDTH:      prdata = 32'(frame_width_reg);
            scbgs_pkg::REG_FRAME_HEIGHT:     prdata = 32'(frame_height_reg);
            default:                         prdata = 32'd0;
        endcase
    end

    // Input word unpacking and the registered copy of the word in work.
    scbgs_pkg::item_t in_item;
    scbgs_pkg::item_t item_reg;
    logic             in_inside;
    logic             in_accept;
    logic             inside_reg;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;

    assign in_item   = scbgs_pkg::item_t'(s_tdata[64:0]);
    assign in_inside = (32'(in_item.pos_x) < 32'(scbgs_pkg::MAX_WIDTH))
                    && (32'(in_item.pos_y) < 32'(scbgs_pkg::MAX_HEIGHT));
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    logic [scbgs_pkg::ADDR_W-1:0] pix_addr_reg;
    logic [scbgs_pkg::ADDR_W-1:0] near_addr_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg     <= in_item;
            inside_reg   <= in_inside;
            pix_addr_reg <= scbgs_pkg::ADDR_W'(
                scbgs_pkg::ADDR_W'(in_item.pos_y) * scbgs_pkg::ADDR_W'(scbgs_pkg::MAX_WIDTH)
                + scbgs_pkg::ADDR_W'(in_item.pos_x));
        end
    end

    // Neighbour coordinate: an axis that would leave the frame, or the store,
    // keeps the pixel's own coordinate.
    logic [scbgs_pkg::COORD_W-1:0]        lim_x;
    logic [scbgs_pkg::COORD_W-1:0]        lim_y;
    logic signed [scbgs_pkg::COORD_W-1:0] try_x;
    logic signed [scbgs_pkg::COORD_W-1:0] try_y;
    logic [8:0]                           near_x;
    logic [7:0]                           near_y;

    always_comb
    begin
        lim_x = (scbgs_pkg::COORD_W'(frame_width_reg) < scbgs_pkg::COORD_W'(scbgs_pkg::MAX_WIDTH))
              ? scbgs_pkg::COORD_W'(frame_width_reg) : scbgs_pkg::COORD_W'(scbgs_pkg::MAX_WIDTH);
        lim_y = (scbgs_pkg::COORD_W'(frame_height_reg) < scbgs_pkg::COORD_W'(scbgs_pkg::MAX_HEIGHT))
              ? scbgs_pkg::COORD_W'(frame_height_reg) : scbgs_pkg::COORD_W'(scbgs_pkg::MAX_HEIGHT);
        try_x = $signed(scbgs_pkg::COORD_W'(item_reg.pos_x))
              + scbgs_pkg::COORD_W'(item_reg.step_x);
        try_y = $signed(scbgs_pkg::COORD_W'(item_reg.pos_y))
              + scbgs_pkg::COORD_W'(item_reg.step_y);
        near_x = (!try_x[scbgs_pkg::COORD_W-1] && (unsigned'(try_x) < lim_x))
               ? try_x[8:0] : item_reg.pos_x;
        near_y = (!try_y[scbgs_pkg::COORD_W-1] && (unsigned'(try_y) < lim_y))
               ? try_y[7:0] : item_reg.pos_y;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            near_addr_reg <= scbgs_pkg::ADDR_W'(
                scbgs_pkg::ADDR_W'(near_y) * scbgs_pkg::ADDR_W'(scbgs_pkg::MAX_WIDTH)
                + scbgs_pkg::ADDR_W'(near_x));
        end
    end

    // Sample memory: one word per pixel, one sample slot written per cycle.
    scbgs_pkg::sample_word_t sample_mem [scbgs_pkg::PIXELS];
    scbgs_pkg::sample_word_t rd_word_reg;

    logic                                wr_en;
    logic [scbgs_pkg::ADDR_W-1:0]        wr_addr;
    logic [scbgs_pkg::SLOT_W-1:0]        wr_slot;
    logic [scbgs_pkg::COLOUR_W-1:0]      colour;

    assign colour = {item_reg.chan2, item_reg.chan1, item_reg.chan0};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sample_mem[wr_addr][wr_slot] <= colour;
        end
        if (state_reg == S_READ)
        begin
            rd_word_reg <= sample_mem[pix_addr_reg];
        end
    end

    // Distance compare against every sample of the word, one squared
    // difference per channel, registered before counting. Each channel uses
    // the absolute difference, so the squares are plain 8 by 8 bit products.
    logic [scbgs_pkg::NUM_SAMPLES-1:0] match_reg;
    logic [scbgs_pkg::CNT_W-1:0]       used;

    assign used = (32'(samples_in_use_reg) < 32'(scbgs_pkg::NUM_SAMPLES))
                ? scbgs_pkg::CNT_W'(samples_in_use_reg)
                : scbgs_pkg::CNT_W'(scbgs_pkg::NUM_SAMPLES);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CMP)
        begin
            for (int k = 0; k < scbgs_pkg::NUM_SAMPLES; k++)
            begin
                logic [7:0]  ad0;
                logic [7:0]  ad1;
                logic [7:0]  ad2;
                logic [15:0] sq0;
                logic [15:0] sq1;
                logic [15:0] sq2;
                logic [17:0] dist2;
                ad0 = (item_reg.chan0 >= rd_word_reg[k][7:0])
                    ? item_reg.chan0 - rd_word_reg[k][7:0]
                    : rd_word_reg[k][7:0] - item_reg.chan0;
                ad1 = (item_reg.chan1 >= rd_word_reg[k][15:8])
                    ? item_reg.chan1 - rd_word_reg[k][15:8]
                    : rd_word_reg[k][15:8] - item_reg.chan1;
                ad2 = (item_reg.chan2 >= rd_word_reg[k][23:16])
                    ? item_reg.chan2 - rd_word_reg[k][23:16]
                    : rd_word_reg[k][23:16] - item_reg.chan2;
                sq0 = {8'd0, ad0} * {8'd0, ad0};
                sq1 = {8'd0, ad1} * {8'd0, ad1};
                sq2 = {8'd0, ad2} * {8'd0, ad2};
                dist2 = {2'd0, sq0} + {2'd0, sq1} + {2'd0, sq2};
                match_reg[k] <= (scbgs_pkg::CNT_W'(k) < used) && (dist2 < radius_sq_reg);
            end
        end
    end

    // Decision and update control.
    logic [scbgs_pkg::CNT_W-1:0] match_count;
    logic                        is_fg;
    logic                        out_space;
    logic                        own_write;
    logic                        near_write;
    logic                        out_valid_reg;
    logic                        fg_reg;

    assign match_count = scbgs_pkg::CNT_W'($countones(match_reg));
    assign is_fg       = !inside_reg
                      || (scbgs_pkg::CMP_W'(match_count)
                          < scbgs_pkg::CMP_W'(required_matches_reg));
    assign out_space   = !out_valid_reg || m_tready;
    assign own_write   = !is_fg && (item_reg.own_draw == 5'd0)
                      && (32'(item_reg.own_slot) < 32'(scbgs_pkg::NUM_SAMPLES));
    assign near_write  = !is_fg && (item_reg.near_draw == 5'd0)
                      && (32'(item_reg.near_slot) < 32'(scbgs_pkg::NUM_SAMPLES));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pix_addr_reg;
        wr_slot = scbgs_pkg::SLOT_W'(item_reg.own_slot);
        unique case (state_reg)
            S_LOAD:
            begin
                wr_en = (32'(item_reg.own_slot) < 32'(scbgs_pkg::NUM_SAMPLES));
            end
            S_DECIDE:
            begin
                wr_en = out_space && own_write;
            end
            S_NEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = near_addr_reg;
                wr_slot = scbgs_pkg::SLOT_W'(item_reg.near_slot);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == scbgs_pkg::MODE_LOAD)
                    begin
                        state_next = in_inside ? S_LOAD : S_IDLE;
                    end
                    else
                    begin
                        state_next = in_inside ? S_READ : S_DECIDE;
                    end
                end
            end
            S_LOAD:   state_next = S_IDLE;
            S_READ:   state_next = S_CMP;
            S_CMP:    state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (out_space)
                begin
                    state_next = near_write ? S_NEAR : S_IDLE;
                end
            end
            S_NEAR:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DECIDE && out_space)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECIDE && out_space)
        begin
            fg_reg <= is_fg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, fg_reg};

endmodule
